// ===== rtl/core/mse_pkg.sv =====
// merge sort engine: shared beat types and default sizes
package mse_pkg;

    localparam int unsigned MAX_ITEMS_DEF = 64;
    localparam int unsigned KEY_WIDTH_DEF = 32;

    typedef struct packed {
        logic signed [31:0] key;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] sorted_key;
        logic               final_res;
    } t_out_beat;

endpackage

// ===== rtl/core/mse_store.sv =====
// merge sort engine: two key banks, one write and one registered read per cycle
module mse_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic             i_wr_bank,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_bank,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_bank0 [DEPTH];
    logic [WIDTH-1:0] r_bank1 [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;
    logic             r_rd_bank;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_bank) begin
            r_bank0[i_wr_addr] <= i_wr_data;
        end
        r_rd0 <= r_bank0[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_bank) begin
            r_bank1[i_wr_addr] <= i_wr_data;
        end
        r_rd1 <= r_bank1[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_bank <= i_rd_bank;
    end

    assign o_rd_data = r_rd_bank ? r_rd1 : r_rd0;

endmodule

// ===== rtl/core/merge_sort_engine.sv =====
// merge sort engine: top level, load / bottom-up merge / drain sequencer
// Keys are taken one per cycle into bank 0 until a beat marked last, or the beat that
// fills the store, closes the set. The set is then sorted ascending and stably by
// bottom-up merge passes that ping-pong between two single-read-port banks: in each pass
// every run pair is primed through the setup, fetch and capture states that load the two
// run heads, and there are ceil(log2 n) passes. The sorted keys then leave in order,
// each read from its bank in the order state and sent from the wait state once the output
// register is free, with final_res on the last one. No input is taken while a set is
// being sorted or drained; the last result may still wait in the output register while
// the next set loads.
module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF,
    parameter int unsigned KEY_WIDTH = mse_pkg::KEY_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mse_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mse_pkg::t_out_beat o_out_beat
);

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned EW = CW + 2;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_FETCHB = 3'd2;
    localparam logic [2:0] S_CAPA   = 3'd3;
    localparam logic [2:0] S_MERGE  = 3'd4;
    localparam logic [2:0] S_ORD    = 3'd5;
    localparam logic [2:0] S_OWAIT  = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_w, n_w;
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_mid, n_mid;
    logic [CW-1:0]        r_hi, n_hi;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_oidx, n_oidx;
    logic                 r_src, n_src;
    logic                 r_fa, n_fa;
    logic                 r_fb, n_fb;
    logic [KEY_WIDTH-1:0] r_a, n_a;
    logic [KEY_WIDTH-1:0] r_b, n_b;
    logic                 r_ovalid, n_ovalid;
    t_out_beat            r_obeat, n_obeat;

    logic                   wr_en;
    logic                   wr_bank;
    logic [AW-1:0]          wr_addr;
    logic [KEY_WIDTH-1:0]   wr_data;
    logic                   rd_bank;
    logic [AW-1:0]          rd_addr;
    logic [KEY_WIDTH-1:0]   rd_data;

    logic [KEY_WIDTH+31:0]  in_ext;
    logic [KEY_WIDTH+31:0]  out_sx;
    logic [CW-1:0]          cnt1;
    logic [EW-1:0]          lo_w;
    logic [EW-1:0]          lo_2w;
    logic [EW-1:0]          n_ext;
    logic [CW:0]            w2;
    logic [KEY_WIDTH-1:0]   cur_a;
    logic [KEY_WIDTH-1:0]   cur_b;
    logic                   a_ok;
    logic                   b_ok;
    logic                   take_a;
    logic [CW-1:0]          i1;
    logic [CW-1:0]          j1;
    logic [CW-1:0]          k1;
    logic                   is_final;
    logic                   out_free;

    mse_store #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (KEY_WIDTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_bank (wr_bank),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_bank (rd_bank),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_obeat;

    assign in_ext = {{KEY_WIDTH{1'b0}}, i_in_beat.key};
    assign out_sx = {{32{1'b0}}, rd_data};
    assign cnt1   = r_count + 1'b1;
    assign n_ext  = {2'b00, r_n};
    assign lo_w   = {2'b00, r_lo} + {2'b00, r_w};
    assign lo_2w  = lo_w + {2'b00, r_w};
    assign w2     = {r_w, 1'b0};

    assign cur_a  = r_fa ? rd_data : r_a;
    assign cur_b  = r_fb ? rd_data : r_b;
    assign a_ok   = (r_i < r_mid);
    assign b_ok   = (r_j < r_hi);
    assign take_a = a_ok && (!b_ok || ($signed(cur_a) <= $signed(cur_b)));
    assign i1     = r_i + 1'b1;
    assign j1     = r_j + 1'b1;
    assign k1     = r_k + 1'b1;

    assign is_final = (r_oidx == (r_n - 1'b1));
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_w      = r_w;
        n_lo     = r_lo;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_oidx   = r_oidx;
        n_src    = r_src;
        n_fa     = r_fa;
        n_fb     = r_fb;
        n_a      = r_a;
        n_b      = r_b;
        n_ovalid = r_ovalid && !i_out_ready;
        n_obeat  = r_obeat;

        wr_en   = 1'b0;
        wr_bank = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = in_ext[KEY_WIDTH-1:0];
        rd_bank = r_src;
        rd_addr = r_j[AW-1:0];

        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    wr_en = 1'b1;
                    if (i_in_beat.last || (cnt1 == CW'(MAX_ITEMS))) begin
                        n_n     = cnt1;
                        n_count = '0;
                        n_src   = 1'b0;
                        n_w     = CW'(1);
                        n_lo    = '0;
                        n_oidx  = '0;
                        n_state = (cnt1 == CW'(1)) ? S_ORD : S_SETUP;
                    end else begin
                        n_count = cnt1;
                    end
                end
            end
            S_SETUP: begin
                n_mid   = (lo_w < n_ext) ? lo_w[CW-1:0] : r_n;
                n_hi    = (lo_2w < n_ext) ? lo_2w[CW-1:0] : r_n;
                n_i     = r_lo;
                n_j     = n_mid;
                n_k     = r_lo;
                rd_addr = r_lo[AW-1:0];
                n_state = S_FETCHB;
            end
            S_FETCHB: begin
                n_a     = rd_data;
                rd_addr = r_j[AW-1:0];
                n_state = S_CAPA;
            end
            S_CAPA: begin
                n_fa    = 1'b0;
                n_fb    = 1'b1;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                wr_en   = 1'b1;
                wr_bank = !r_src;
                wr_addr = r_k[AW-1:0];
                wr_data = take_a ? cur_a : cur_b;
                n_k     = k1;
                if (take_a) begin
                    rd_addr = i1[AW-1:0];
                    n_i     = i1;
                    n_b     = cur_b;
                    n_fa    = 1'b1;
                    n_fb    = 1'b0;
                end else begin
                    rd_addr = j1[AW-1:0];
                    n_j     = j1;
                    n_a     = cur_a;
                    n_fa    = 1'b0;
                    n_fb    = 1'b1;
                end
                if (k1 == r_hi) begin
                    if (lo_2w >= n_ext) begin
                        n_src = !r_src;
                        if (w2 >= {1'b0, r_n}) begin
                            n_oidx  = '0;
                            n_state = S_ORD;
                        end else begin
                            n_w     = w2[CW-1:0];
                            n_lo    = '0;
                            n_state = S_SETUP;
                        end
                    end else begin
                        n_lo    = lo_2w[CW-1:0];
                        n_state = S_SETUP;
                    end
                end
            end
            S_ORD: begin
                rd_addr = r_oidx[AW-1:0];
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                rd_addr = r_oidx[AW-1:0];
                if (out_free) begin
                    n_ovalid           = 1'b1;
                    n_obeat.sorted_key = out_sx[31:0];
                    n_obeat.final_res  = is_final;
                    if (is_final) begin
                        n_state = S_LOAD;
                    end else begin
                        n_oidx  = r_oidx + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_src    <= 1'b0;
            r_fa     <= 1'b0;
            r_fb     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_src    <= n_src;
            r_fa     <= n_fa;
            r_fb     <= n_fb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_w     <= n_w;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_oidx  <= n_oidx;
        r_a     <= n_a;
        r_b     <= n_b;
        r_obeat <= n_obeat;
    end

endmodule

// ===== bench/tb.sv =====
// testbench for merge_sort_engine: directed and random key sets checked against a sorting predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mse_pkg::*;

    localparam int unsigned SET_MAX = MAX_ITEMS_DEF;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 100;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DIR_ROWS = 23;
    localparam int unsigned KEYS_PER_PHASE = 4;

    typedef enum int unsigned {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH,
        PH_COUNT
    } t_phase;

    typedef struct packed {
        logic signed [31:0] key;
        logic               last;
        logic               typed;
        logic signed [31:0] want;
    } t_dir_row;

    // single-key sets carry their answer; longer sets go through the predictor
    t_dir_row dir_table [DIR_ROWS] = '{
        '{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff},
        '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
        '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
        '{32'shffffffff, 1'b1, 1'b1, 32'shffffffff},
        '{32'sh00000001, 1'b1, 1'b1, 32'sh00000001},
        '{32'sh00000003, 1'b0, 1'b0, 32'sh0},
        '{32'shfffffffe, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000003, 1'b0, 1'b0, 32'sh0},
        '{32'sh80000000, 1'b0, 1'b0, 32'sh0},
        '{32'sh7fffffff, 1'b0, 1'b0, 32'sh0},
        '{32'shfffffffe, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000000, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000003, 1'b1, 1'b0, 32'sh0},
        '{32'sh00000001, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000002, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000003, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000004, 1'b1, 1'b0, 32'sh0},
        '{32'sh00000004, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000003, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000002, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000001, 1'b1, 1'b0, 32'sh0},
        '{32'sh7fffffff, 1'b0, 1'b0, 32'sh0},
        '{32'sh80000000, 1'b1, 1'b0, 32'sh0}
    };

    logic signed [31:0] extreme_keys [4] = '{
        32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    logic signed [31:0] pending_keys [SET_MAX];
    int unsigned        pending_count = 0;
    t_out_beat          sorted_keys_due [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned keys_sent = 0;
    int unsigned sets_closed = 0;
    int unsigned keys_checked = 0;
    int unsigned mismatches = 0;

    merge_sort_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stable ascending sort of the held set once it closes
    function automatic void load_key(t_in_beat b);
        int                 i;
        int                 j;
        int unsigned        n;
        logic signed [31:0] k;
        pending_keys[pending_count] = b.key;
        pending_count++;
        if (!b.last && pending_count < SET_MAX) begin
            return;
        end
        n = pending_count;
        for (i = 1; i < n; i++) begin
            k = pending_keys[i];
            j = i - 1;
            while (j >= 0 && pending_keys[j] > k) begin
                pending_keys[j + 1] = pending_keys[j];
                j--;
            end
            pending_keys[j + 1] = k;
        end
        for (i = 0; i < n; i++) begin
            sorted_keys_due.push_back('{sorted_key: pending_keys[i], final_res: (i == n - 1)});
        end
        pending_count = 0;
        sets_closed++;
    endfunction

    function automatic void set_phase(t_phase ph);
        case (ph)
            PH_SENDER_IDLE: begin
                send_idle_pct = 58;
                recv_stall_pct = 0;
            end
            PH_RECEIVER_STALL: begin
                send_idle_pct = 0;
                recv_stall_pct = 58;
            end
            PH_BOTH: begin
                send_idle_pct = 18;
                recv_stall_pct = 18;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what, t_out_beat want, t_out_beat got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch %0d (%s): want key %0d final %0b, got key %0d final %0b",
                     mismatches, what, want.sorted_key, want.final_res,
                     got.sorted_key, got.final_res);
        end
    endfunction

    task automatic send_key(input t_in_beat b);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        keys_sent++;
        load_key(b);
    endtask

    // fill_store: no beat of the set marks last before the store is full
    task automatic send_set(input int unsigned size, input bit fill_store);
        t_in_beat    b;
        int unsigned i;
        for (i = 0; i < size; i++) begin
            case ($urandom_range(3))
                1: b.key = 32'($urandom_range(8)) - 32'd4;
                2: b.key = extreme_keys[2'($urandom_range(3))];
                default: b.key = $urandom;
            endcase
            if (i != size - 1) begin
                b.last = 1'b0;
            end else if (fill_store) begin
                b.last = 1'($urandom_range(1));
            end else begin
                b.last = 1'b1;
            end
            send_key(b);
        end
    endtask

    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_done) begin
            hold_done <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (sorted_keys_due.size() == 0) begin
                note_mismatch("no beat expected", '0, out_beat);
            end else begin
                if (out_beat.sorted_key !== sorted_keys_due[0].sorted_key ||
                    out_beat.final_res !== sorted_keys_due[0].final_res) begin
                    note_mismatch("wrong beat", sorted_keys_due[0], out_beat);
                end
                void'(sorted_keys_due.pop_front());
                keys_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, sorted_keys_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_in_beat    b;
        int unsigned r;
        int unsigned p;
        int unsigned sent;
        int unsigned size;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_phase(PH_STEADY);
        for (r = 0; r < DIR_ROWS; r++) begin
            b.key = dir_table[r].key;
            b.last = dir_table[r].last;
            send_key(b);
            if (dir_table[r].typed) begin
                sorted_keys_due[sorted_keys_due.size() - 1] = '{dir_table[r].want, 1'b1};
            end
        end

        for (p = 0; p < PH_COUNT; p++) begin
            set_phase(t_phase'(p));
            // long receiver hold so the block fills and backs up its input
            if (p == PH_STEADY) begin
                hold_asks++;
            end
            sent = 0;
            while (sent < KEYS_PER_PHASE) begin
                size = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
                send_set(size, 1'b0);
                sent += size;
            end
            if (p == PH_RECEIVER_STALL) begin
                send_set(SET_MAX, 1'b1);
            end
        end
        in_valid <= 1'b0;

        while (sorted_keys_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d keys in %0d sets, including a full store, over four idling phases",
                 keys_sent, sets_closed);
        $display("checked %0d sorted beats, %0d mismatching", keys_checked, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
